@@ src/lmfs_pkg.sv @@
// ---------------------------------------------------------------------------
// lmfs_pkg: shared constants for the LED matrix frame store
// Field widths and action codes used by the top level and its units.
// ---------------------------------------------------------------------------
package lmfs_pkg;

    localparam int ACT_W   = 3;
    localparam int RAW_W   = 8;
    localparam int COLOR_W = 16;
    localparam int TURN_W  = 2;

    localparam logic [ACT_W-1:0] ACT_WRITE   = 3'd0;
    localparam logic [ACT_W-1:0] ACT_READ    = 3'd1;
    localparam logic [ACT_W-1:0] ACT_PATTERN = 3'd2;
    localparam logic [ACT_W-1:0] ACT_ROTATE  = 3'd3;
    localparam logic [ACT_W-1:0] ACT_FILL    = 3'd4;

endpackage

@@ src/lmfs_ram.sv @@
// ---------------------------------------------------------------------------
// lmfs_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ---------------------------------------------------------------------------
module lmfs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/lmfs_fold.sv @@
// ---------------------------------------------------------------------------
// lmfs_fold: coordinate folding unit
// Clamps a negative index to zero and reduces it modulo the matrix side
// in two register stages (reciprocal multiply, then remainder with correction).
// ---------------------------------------------------------------------------
module lmfs_fold
    import lmfs_pkg::*;
#(
    parameter int MATRIX_SIDE = 8
) (
    input  logic                           i_clk,
    input  logic signed [RAW_W-1:0]        i_raw,
    output logic [$clog2(MATRIX_SIDE)-1:0] o_coord
);

    localparam int CW     = $clog2(MATRIX_SIDE);
    localparam int VW     = RAW_W - 1;
    localparam int RECIP  = (2 ** 16) / MATRIX_SIDE;
    localparam int PW     = VW + 17;
    localparam logic [16:0] RecipK = 17'(RECIP);
    localparam logic [VW:0] SideK  = (VW + 1)'(MATRIX_SIDE);

    logic [VW-1:0] v;
    logic [PW-1:0] prod;
    logic [VW-1:0] r_v;
    logic [VW-1:0] r_q;
    logic [VW:0]   qs;
    logic [VW:0]   diff;
    logic [VW:0]   rem;
    logic [CW-1:0] r_rem;

    // negative counts as zero
    assign v    = i_raw[RAW_W-1] ? '0 : i_raw[VW-1:0];
    assign prod = PW'(v) * PW'(RecipK);

    always_ff @(posedge i_clk) begin
        r_v <= v;
        r_q <= prod[16 +: VW];
    end

    // quotient estimate is exact or one low
    assign qs   = (VW + 1)'(r_q) * SideK;
    assign diff = {1'b0, r_v} - qs;
    assign rem  = (diff >= SideK) ? diff - SideK : diff;

    always_ff @(posedge i_clk) begin
        r_rem <= CW'(rem);
    end

    assign o_coord = r_rem;

endmodule

@@ src/lmfs_slot.sv @@
// ---------------------------------------------------------------------------
// lmfs_slot: quarter-turn slot mapper
// Maps a (row, column) pair turned by 0..3 quarter turns to a linear
// store address; shared by pixel accesses and the rotate sweep.
// ---------------------------------------------------------------------------
module lmfs_slot
    import lmfs_pkg::*;
#(
    parameter int MATRIX_SIDE = 8
) (
    input  logic [$clog2(MATRIX_SIDE)-1:0]               i_row,
    input  logic [$clog2(MATRIX_SIDE)-1:0]               i_col,
    input  logic [TURN_W-1:0]                            i_turns,
    output logic [$clog2(MATRIX_SIDE*MATRIX_SIDE)-1:0]   o_slot
);

    localparam int CW = $clog2(MATRIX_SIDE);
    localparam int AW = $clog2(MATRIX_SIDE * MATRIX_SIDE);
    localparam logic [CW-1:0] SMax  = CW'(MATRIX_SIDE - 1);
    localparam logic [AW-1:0] SideA = AW'(MATRIX_SIDE);

    logic [CW-1:0] nr;
    logic [CW-1:0] nc;

    always_comb begin
        case (i_turns)
            2'd1: begin
                nr = SMax - i_col;
                nc = i_row;
            end
            2'd2: begin
                nr = SMax - i_row;
                nc = SMax - i_col;
            end
            2'd3: begin
                nr = i_col;
                nc = SMax - i_row;
            end
            default: begin
                nr = i_row;
                nc = i_col;
            end
        endcase
    end

    assign o_slot = AW'(nr) * SideA + AW'(nc);

endmodule

@@ src/led_matrix_frame_store_rotation.sv @@
// ---------------------------------------------------------------------------
// led_matrix_frame_store_rotation: RGB565 frame store with quarter turns
// Square pixel store with write, read, rotated write, whole-store rotate and
// fill. Two RAM banks ping-pong on rotate; fill is a valid-bit clear.
// ---------------------------------------------------------------------------
//  channel   direction  handshake                  payload
//  command   in         start & !busy              i_action, i_row_index,
//                                                  i_column_index, i_pixel_color,
//                                                  i_turn_code
//  result    out        o_result_valid (1 cycle)   o_read_color
//  config    in         i_cfg_we                   i_cfg_wdata (rotation code)
//
// Items pass fold, remainder, slot, then write (write, pattern write) or read
// request and read data (read); fill and unused codes end at accept; rotate
// sweeps one entry per cycle through the slot mapper, then drains the last
// write. Folding uses a two-stage divider unit. Reset clears the store at once
// (valid bits read back as fill color 0). Results are registered, not stalled.
// ---------------------------------------------------------------------------
module led_matrix_frame_store_rotation
    import lmfs_pkg::*;
#(
    parameter int MATRIX_SIDE = 8
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [ACT_W-1:0]          i_action,
    input  logic signed [RAW_W-1:0]   i_row_index,
    input  logic signed [RAW_W-1:0]   i_column_index,
    input  logic [COLOR_W-1:0]        i_pixel_color,
    input  logic [TURN_W-1:0]         i_turn_code,
    output logic                      o_result_valid,
    output logic [COLOR_W-1:0]        o_read_color,
    input  logic                      i_cfg_we,
    input  logic [TURN_W-1:0]         i_cfg_wdata
);

    localparam int N  = MATRIX_SIDE * MATRIX_SIDE;
    localparam int CW = $clog2(MATRIX_SIDE);
    localparam int AW = $clog2(N);
    localparam logic [CW-1:0] CLast = CW'(MATRIX_SIDE - 1);
    localparam logic [AW-1:0] ALast = AW'(N - 1);

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_FOLD   = 9'b000000010,
        ST_REM    = 9'b000000100,
        ST_SLOT   = 9'b000001000,
        ST_WRITE  = 9'b000010000,
        ST_RDREQ  = 9'b000100000,
        ST_RDDATA = 9'b001000000,
        ST_SWEEP  = 9'b010000000,
        ST_DRAIN  = 9'b100000000
    } t_state;

    t_state r_state;
    t_state n_state;

    logic                     accept;
    logic [TURN_W-1:0]        r_rotation;
    logic [ACT_W-1:0]         r_action;
    logic signed [RAW_W-1:0]  r_row;
    logic signed [RAW_W-1:0]  r_col;
    logic [COLOR_W-1:0]       r_color;
    logic [TURN_W-1:0]        r_total;
    logic [COLOR_W-1:0]       r_fill;
    logic                     r_bank;
    logic [N-1:0]             r_valid [2];
    logic                     r_rd_vld;
    logic [CW-1:0]            r_i;
    logic [CW-1:0]            r_j;
    logic [AW-1:0]            r_k;
    logic [AW-1:0]            r_slot;
    logic                     r_wpend;
    logic                     r_done;
    logic [COLOR_W-1:0]       r_out;

    logic [CW-1:0]            fold_row;
    logic [CW-1:0]            fold_col;
    logic [CW-1:0]            map_row;
    logic [CW-1:0]            map_col;
    logic [TURN_W-1:0]        map_turns;
    logic [AW-1:0]            map_slot;
    logic [AW-1:0]            raddr;
    logic                     we_pixel;
    logic                     we_sweep;
    logic [1:0]               we_bank;
    logic [COLOR_W-1:0]       wdata;
    logic [COLOR_W-1:0]       rdata0;
    logic [COLOR_W-1:0]       rdata1;
    logic [COLOR_W-1:0]       rdata_act;
    logic [COLOR_W-1:0]       rd_color;

    assign busy   = (r_state != ST_IDLE);
    assign accept = start && !busy;

    // ---- folding units ----
    lmfs_fold #(.MATRIX_SIDE(MATRIX_SIDE)) u_fold_row (
        .i_clk   (i_clk),
        .i_raw   (r_row),
        .o_coord (fold_row)
    );

    lmfs_fold #(.MATRIX_SIDE(MATRIX_SIDE)) u_fold_col (
        .i_clk   (i_clk),
        .i_raw   (r_col),
        .o_coord (fold_col)
    );

    // ---- shared slot mapper ----
    always_comb begin
        if (r_state == ST_SWEEP) begin
            map_row   = r_i;
            map_col   = r_j;
            map_turns = r_total;
        end else begin
            map_row   = fold_row;
            map_col   = fold_col;
            map_turns = (r_action == ACT_PATTERN) ? r_rotation : '0;
        end
    end

    lmfs_slot #(.MATRIX_SIDE(MATRIX_SIDE)) u_slot (
        .i_row   (map_row),
        .i_col   (map_col),
        .i_turns (map_turns),
        .o_slot  (map_slot)
    );

    // ---- store banks ----
    assign raddr     = (r_state == ST_SWEEP) ? r_k : r_slot;
    assign rdata_act = r_bank ? rdata1 : rdata0;
    assign rd_color  = r_rd_vld ? rdata_act : r_fill;

    assign we_pixel = (r_state == ST_WRITE);
    assign we_sweep = r_wpend && ((r_state == ST_SWEEP) || (r_state == ST_DRAIN));
    // pixel writes go to the active bank, sweep writes to the other one
    assign we_bank[0] = (we_pixel && !r_bank) || (we_sweep && r_bank);
    assign we_bank[1] = (we_pixel && r_bank) || (we_sweep && !r_bank);
    assign wdata      = we_sweep ? rd_color : r_color;

    lmfs_ram #(.WIDTH(COLOR_W), .DEPTH(N)) u_bank0 (
        .i_clk   (i_clk),
        .i_we    (we_bank[0]),
        .i_waddr (r_slot),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata0)
    );

    lmfs_ram #(.WIDTH(COLOR_W), .DEPTH(N)) u_bank1 (
        .i_clk   (i_clk),
        .i_we    (we_bank[1]),
        .i_waddr (r_slot),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata1)
    );

    // ---- sequencer ----
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (i_action)
                        ACT_WRITE, ACT_READ, ACT_PATTERN: n_state = ST_FOLD;
                        ACT_ROTATE:                       n_state = ST_SWEEP;
                        default:                          n_state = ST_IDLE;
                    endcase
                end
            end
            ST_FOLD:   n_state = ST_REM;
            ST_REM:    n_state = ST_SLOT;
            ST_SLOT:   n_state = (r_action == ACT_READ) ? ST_RDREQ : ST_WRITE;
            ST_WRITE:  n_state = ST_IDLE;
            ST_RDREQ:  n_state = ST_RDDATA;
            ST_RDDATA: n_state = ST_IDLE;
            ST_SWEEP:  n_state = (r_k == ALast) ? ST_DRAIN : ST_SWEEP;
            ST_DRAIN:  n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_rotation <= '0;
            r_fill     <= '0;
            r_bank     <= 1'b0;
            r_valid[0] <= '0;
            r_valid[1] <= '0;
            r_wpend    <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= 1'b0;
            if (i_cfg_we) begin
                r_rotation <= i_cfg_wdata;
            end
            if (we_bank[0]) begin
                r_valid[0][r_slot] <= 1'b1;
            end
            if (we_bank[1]) begin
                r_valid[1][r_slot] <= 1'b1;
            end
            r_wpend <= (r_state == ST_SWEEP);
            case (r_state)
                ST_IDLE: begin
                    if (accept && (i_action != ACT_WRITE) && (i_action != ACT_READ)
                        && (i_action != ACT_PATTERN) && (i_action != ACT_ROTATE)) begin
                        r_done <= 1'b1;
                    end
                    // fill: drop every entry of the active bank back to the fill color
                    if (accept && (i_action == ACT_FILL)) begin
                        r_fill          <= i_pixel_color;
                        r_valid[r_bank] <= '0;
                    end
                end
                ST_WRITE:  r_done <= 1'b1;
                ST_RDDATA: r_done <= 1'b1;
                ST_DRAIN: begin
                    r_bank <= !r_bank;
                    r_done <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    // payload, slot, sweep counters and result registers
    always_ff @(posedge i_clk) begin
        r_rd_vld <= r_valid[r_bank][raddr];
        if (accept) begin
            r_action <= i_action;
            r_row    <= i_row_index;
            r_col    <= i_column_index;
            r_color  <= i_pixel_color;
            r_total  <= TURN_W'(i_turn_code + r_rotation);
            r_i      <= '0;
            r_j      <= '0;
            r_k      <= '0;
        end
        if ((r_state == ST_SLOT) || (r_state == ST_SWEEP)) begin
            r_slot <= map_slot;
        end
        if (r_state == ST_SWEEP) begin
            r_k <= r_k + 1'b1;
            if (r_j == CLast) begin
                r_j <= '0;
                r_i <= r_i + 1'b1;
            end else begin
                r_j <= r_j + 1'b1;
            end
        end
        if (r_state == ST_IDLE) begin
            r_out <= '0;
        end else if (r_state == ST_RDDATA) begin
            r_out <= rd_color;
        end else if (r_state == ST_WRITE) begin
            r_out <= '0;
        end else if (r_state == ST_DRAIN) begin
            r_out <= '0;
        end
    end

    assign o_result_valid = r_done;
    assign o_read_color   = r_out;

endmodule

@@ tb/frame_store_checker.sv @@
// ---------------------------------------------------------------------------
// frame_store_checker: shadow frame store and result comparison
// Watches the command, config and result ports of the LED matrix frame store,
// keeps its own 8x8 pixel copy and rotation setting, works out the color that
// each accepted item must return and compares it against the result stream.
// ---------------------------------------------------------------------------
module frame_store_checker
    import lmfs_pkg::*;
#(
    parameter int SIDE = 8
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic                    i_busy,
    input  logic [ACT_W-1:0]        i_action,
    input  logic signed [RAW_W-1:0] i_row_index,
    input  logic signed [RAW_W-1:0] i_column_index,
    input  logic [COLOR_W-1:0]      i_pixel_color,
    input  logic [TURN_W-1:0]       i_turn_code,
    input  logic                    i_result_valid,
    input  logic [COLOR_W-1:0]      i_read_color,
    input  logic                    i_cfg_we,
    input  logic [TURN_W-1:0]       i_cfg_wdata,
    output int                      o_fail_count,
    output int                      o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [COLOR_W-1:0] shadow_pixels [SIDE*SIDE];
    logic [TURN_W-1:0]  display_turns;
    logic [COLOR_W-1:0] expected_colors [$];

    // negative coordinates clamp to zero before wrapping
    function automatic int fold_coord(input logic signed [RAW_W-1:0] raw);
        if (raw < 0) begin
            return 0;
        end
        return int'(raw) % SIDE;
    endfunction

    function automatic int spun_addr(input int r, input int c, input logic [TURN_W-1:0] t);
        int last;
        last = SIDE - 1;
        case (t)
            2'd1: begin
                return (last - c) * SIDE + r;
            end
            2'd2: begin
                return (last - r) * SIDE + (last - c);
            end
            2'd3: begin
                return c * SIDE + (last - r);
            end
            default: begin
                return r * SIDE + c;
            end
        endcase
    endfunction

    // update the shadow store and return the color the item must produce
    function automatic logic [COLOR_W-1:0] apply_command(
        input logic [ACT_W-1:0]        act,
        input logic signed [RAW_W-1:0] row_raw,
        input logic signed [RAW_W-1:0] col_raw,
        input logic [COLOR_W-1:0]      color,
        input logic [TURN_W-1:0]       turns
    );
        int r;
        int c;
        logic [TURN_W-1:0]  net_turns;
        logic [COLOR_W-1:0] snapshot [SIDE*SIDE];
        logic [COLOR_W-1:0] read_back;
        r = fold_coord(row_raw);
        c = fold_coord(col_raw);
        read_back = '0;
        case (act)
            ACT_WRITE: begin
                shadow_pixels[r*SIDE + c] = color;
            end
            ACT_READ: begin
                read_back = shadow_pixels[r*SIDE + c];
            end
            ACT_PATTERN: begin
                shadow_pixels[spun_addr(r, c, display_turns)] = color;
            end
            ACT_ROTATE: begin
                net_turns = turns + display_turns;
                snapshot = shadow_pixels;
                for (int i = 0; i < SIDE; i++) begin
                    for (int j = 0; j < SIDE; j++) begin
                        shadow_pixels[spun_addr(i, j, net_turns)] = snapshot[i*SIDE + j];
                    end
                end
            end
            ACT_FILL: begin
                foreach (shadow_pixels[k]) begin
                    shadow_pixels[k] = color;
                end
            end
            default: begin
            end
        endcase
        return read_back;
    endfunction

    always @(posedge i_clk) begin : monitor
        logic [COLOR_W-1:0] want;
        if (!i_rst_n) begin
            foreach (shadow_pixels[k]) begin
                shadow_pixels[k] = '0;
            end
            display_turns = '0;
            expected_colors.delete();
            o_fail_count = 0;
        end else begin
            if (i_result_valid) begin
                if (expected_colors.size() == 0) begin
                    $error("read_color: no result expected, got %h", i_read_color);
                    o_fail_count++;
                end else begin
                    want = expected_colors.pop_front();
                    if (i_read_color !== want) begin
                        $error("read_color: expected %h, got %h", want, i_read_color);
                        o_fail_count++;
                    end
                end
            end
            if (i_start && !i_busy) begin
                expected_colors.push_back(apply_command(i_action, i_row_index,
                    i_column_index, i_pixel_color, i_turn_code));
            end
            if (i_cfg_we) begin
                display_turns = i_cfg_wdata;
            end
        end
        o_pending = expected_colors.size();
    end

endmodule

@@ tb/led_matrix_frame_store_rotation_tb.sv @@
// ---------------------------------------------------------------------------
// led_matrix_frame_store_rotation_tb: command stimulus and verdict
// Drives directed and random pixel, rotate and fill commands through the
// start/busy handshake across several display rotation settings, with random
// sender gaps; the checker beside the block compares every result.
// ---------------------------------------------------------------------------
module led_matrix_frame_store_rotation_tb
    import lmfs_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int ITEMS_PER_PHASE = 160;
    localparam logic [ACT_W-1:0] ACT_SPARE_LO = 3'd5;
    localparam logic [ACT_W-1:0] ACT_SPARE_MID = 3'd6;
    localparam logic [ACT_W-1:0] ACT_SPARE_HI = 3'd7;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    start = 1'b0;
    logic                    busy;
    logic [ACT_W-1:0]        i_action = '0;
    logic signed [RAW_W-1:0] i_row_index = '0;
    logic signed [RAW_W-1:0] i_column_index = '0;
    logic [COLOR_W-1:0]      i_pixel_color = '0;
    logic [TURN_W-1:0]       i_turn_code = '0;
    logic                    o_result_valid;
    logic [COLOR_W-1:0]      o_read_color;
    logic                    i_cfg_we = 1'b0;
    logic [TURN_W-1:0]       i_cfg_wdata = '0;

    int  fail_count;
    int  pending;
    int  quiet_cycles = 0;
    bit  sender_gaps = 1'b1;

    logic [TURN_W-1:0] rotation_plan [6] = '{2'd3, 2'd1, 2'd0, 2'd2, 2'd3, 2'd0};

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    led_matrix_frame_store_rotation u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_action       (i_action),
        .i_row_index    (i_row_index),
        .i_column_index (i_column_index),
        .i_pixel_color  (i_pixel_color),
        .i_turn_code    (i_turn_code),
        .o_result_valid (o_result_valid),
        .o_read_color   (o_read_color),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata)
    );

    frame_store_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_action       (i_action),
        .i_row_index    (i_row_index),
        .i_column_index (i_column_index),
        .i_pixel_color  (i_pixel_color),
        .i_turn_code    (i_turn_code),
        .i_result_valid (o_result_valid),
        .i_read_color   (o_read_color),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    // end the run if nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_result_valid) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("led_matrix_frame_store_rotation: mismatch");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic issue(
        input logic [ACT_W-1:0]        act,
        input logic signed [RAW_W-1:0] row,
        input logic signed [RAW_W-1:0] col,
        input logic [COLOR_W-1:0]      color,
        input logic [TURN_W-1:0]       turns
    );
        int gap;
        if (sender_gaps && $urandom_range(0, 2) == 0) begin
            gap = $urandom_range(1, 7);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start          <= 1'b1;
        i_action       <= act;
        i_row_index    <= row;
        i_column_index <= col;
        i_pixel_color  <= color;
        i_turn_code    <= turns;
        // hold the item until the block takes it
        do @(posedge i_clk); while (busy);
    endtask

    // drain outstanding results, then write the rotation register
    task automatic set_rotation(input logic [TURN_W-1:0] turns);
        start <= 1'b0;
        do @(negedge i_clk); while (pending != 0 || busy);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= turns;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    function automatic logic signed [RAW_W-1:0] pick_coord();
        if ($urandom_range(0, 3) != 0) begin
            return RAW_W'($urandom_range(0, 7));
        end
        return RAW_W'($urandom_range(0, 255));
    endfunction

    task automatic issue_random();
        int pick;
        logic [ACT_W-1:0] act;
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
            act = ACT_WRITE;
        end else if (pick < 60) begin
            act = ACT_READ;
        end else if (pick < 78) begin
            act = ACT_PATTERN;
        end else if (pick < 88) begin
            act = ACT_ROTATE;
        end else if (pick < 91) begin
            act = ACT_FILL;
        end else begin
            act = ACT_FILL + ACT_W'($urandom_range(1, 3));
        end
        issue(act, pick_coord(), pick_coord(), COLOR_W'($urandom), TURN_W'($urandom));
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // corners, clamping, every action and the unused codes
        issue(ACT_READ,    8'sd0,   8'sd0,   16'h1111, 2'd0);
        issue(ACT_WRITE,   8'sh80,  8'sd127, 16'hFFFF, 2'd3);
        issue(ACT_WRITE,   8'sd127, -8'sd1,  16'h0001, 2'd0);
        issue(ACT_WRITE,   8'sd7,   8'sd7,   16'h8000, 2'd1);
        issue(ACT_WRITE,   8'sd3,   8'sd5,   16'hA5A5, 2'd2);
        issue(ACT_READ,    8'sd0,   8'sd7,   16'h0000, 2'd0);
        issue(ACT_READ,    -8'sd5,  8'sd127, 16'hFFFF, 2'd3);
        issue(ACT_PATTERN, 8'sd1,   8'sd2,   16'h1234, 2'd0);
        issue(ACT_ROTATE,  8'sd0,   8'sd0,   16'h0000, 2'd1);
        issue(ACT_READ,    8'sd7,   8'sd7,   16'h0000, 2'd0);
        issue(ACT_ROTATE,  -8'sd1,  -8'sd1,  16'hFFFF, 2'd2);
        issue(ACT_ROTATE,  8'sd0,   8'sd0,   16'h0000, 2'd3);
        issue(ACT_ROTATE,  8'sd0,   8'sd0,   16'h0000, 2'd0);
        issue(ACT_READ,    8'sd0,   8'sd0,   16'h0000, 2'd0);
        issue(ACT_SPARE_LO,  8'sd7,   8'sd7,   16'hFFFF, 2'd3);
        issue(ACT_SPARE_MID, 8'sh80,  8'sh80,  16'h5A5A, 2'd1);
        issue(ACT_SPARE_HI,  8'sd127, 8'sd127, 16'hC3C3, 2'd2);
        issue(ACT_READ,    8'sd7,   8'sd0,   16'h0000, 2'd0);
        issue(ACT_FILL,    8'sd0,   8'sd0,   16'hFFFF, 2'd0);
        issue(ACT_READ,    8'sd4,   8'sd4,   16'h0000, 2'd0);
        issue(ACT_FILL,    8'sd5,   8'sd5,   16'h0000, 2'd3);
        issue(ACT_READ,    8'sd127, 8'sd127, 16'h0000, 2'd0);

        foreach (rotation_plan[p]) begin
            set_rotation(rotation_plan[p]);
            // last phase runs without sender gaps
            sender_gaps = (p != $size(rotation_plan) - 1);
            issue(ACT_PATTERN, 8'sd0, 8'sd7, 16'hBEEF, 2'd0);
            issue(ACT_READ, 8'sd0, 8'sd7, 16'h0000, 2'd0);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                issue_random();
            end
        end

        start <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("led_matrix_frame_store_rotation: match");
        end else begin
            $display("led_matrix_frame_store_rotation: mismatch");
        end
        $finish;
    end

endmodule
